>>> src/rqld_pkg.sv
// Shared types and constants for the ring queue with lazy delete.
`timescale 1ns / 1ps
`default_nettype none

package rqld_pkg;

  localparam int ADDR_BITS_DEF = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FUNC_W = 3;
  localparam int STATUS_W = 2;
  localparam int SIZE_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_PEEK   = 3'd2,
    FN_READ   = 3'd3,
    FN_DELETE = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_SCAN  = 2'd2
  } state_e;

  typedef struct packed {
    logic data_we;
    logic vld_we;
    logic vld_wbit;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> src/ring_queue_with_lazy_delete_unit.sv
// Top level of the ring queue with lazy delete: size register, ring mask, sequencer, store.
// Sequence: a command accepted while idle moves to the scan state, which raises the registered
//   result strobe; push and pop stay in the scan state while they step past skipped slots.
// Busy stays high until each result, so commands never overlap; the read port is registered.
// Reset and every size write start a clearing sweep over 2**s slots, s being size clamped
//   to 1..ADDR_BITS (256 by default), with busy high. The result receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module ring_queue_with_lazy_delete_unit #(
  parameter int ADDR_BITS = rqld_pkg::ADDR_BITS_DEF,
  parameter int DATA_WIDTH = rqld_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rqld_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [DATA_WIDTH-1:0]         data_in_i,
  input  wire logic [ADDR_BITS-1:0]          slot_index_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rqld_pkg::SIZE_W-1:0]   size_log2_i,
  output logic                               done_o,
  output logic      [rqld_pkg::STATUS_W-1:0] status_o,
  output logic      [DATA_WIDTH-1:0]         data_out_o,
  output logic      [ADDR_BITS-1:0]          index_out_o,
  output logic      [ADDR_BITS:0]            live_count_o
);
  import rqld_pkg::*;

  logic [SIZE_W-1:0]     size_q;
  logic                  cfg_we;
  logic [ADDR_BITS-1:0]  mask;
  logic [ADDR_BITS-1:0]  raddr;
  logic [ADDR_BITS-1:0]  waddr;
  logic [DATA_WIDTH-1:0] wdata;
  mem_ctl_t              ctl;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  rd_vld;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_LOG2_RST;
    end else if (cfg_we) begin
      size_q <= size_log2_i;
    end
  end

  always_comb begin
    int unsigned eff;
    eff = int'(size_q);
    if (eff < 1) eff = 1;
    if (eff > ADDR_BITS) eff = ADDR_BITS;
    for (int i = 0; i < ADDR_BITS; i++) begin
      mask[i] = (i < eff);
    end
  end

  rqld_seq #(
    .ADDR_BITS  (ADDR_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .func_i       (func_i),
    .data_in_i    (data_in_i),
    .slot_index_i (slot_index_i),
    .cfg_we_i     (cfg_we),
    .mask_i       (mask),
    .raddr_o      (raddr),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .ctl_o        (ctl),
    .rd_data_i    (rd_data),
    .rd_vld_i     (rd_vld),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .index_out_o  (index_out_o),
    .live_count_o (live_count_o)
  );

  rqld_store #(
    .ADDR_BITS  (ADDR_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .raddr_i   (raddr),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .ctl_i     (ctl),
    .rd_data_o (rd_data),
    .rd_vld_o  (rd_vld)
  );

endmodule

`default_nettype wire

>>> src/rqld_store.sv
// Slot data and valid-bit memories with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rqld_store #(
  parameter int ADDR_BITS = rqld_pkg::ADDR_BITS_DEF,
  parameter int DATA_WIDTH = rqld_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic [ADDR_BITS-1:0]  raddr_i,
  input  wire logic [ADDR_BITS-1:0]  waddr_i,
  input  wire logic [DATA_WIDTH-1:0] wdata_i,
  input  wire rqld_pkg::mem_ctl_t    ctl_i,
  output logic      [DATA_WIDTH-1:0] rd_data_o,
  output logic                       rd_vld_o
);
  import rqld_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_WIDTH-1:0] data_mem [DEPTH];
  logic                  vld_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.data_we) begin
      data_mem[waddr_i] <= wdata_i;
    end
    rd_data_o <= data_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld_we) begin
      vld_mem[waddr_i] <= ctl_i.vld_wbit;
    end
    rd_vld_o <= vld_mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/rqld_seq.sv
// Operation sequencer: pointers, live count, slot scan, clearing sweep, result register.
`timescale 1ns / 1ps
`default_nettype none

module rqld_seq #(
  parameter int ADDR_BITS = rqld_pkg::ADDR_BITS_DEF,
  parameter int DATA_WIDTH = rqld_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [rqld_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [DATA_WIDTH-1:0]         data_in_i,
  input  wire logic [ADDR_BITS-1:0]          slot_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ADDR_BITS-1:0]          mask_i,
  output logic      [ADDR_BITS-1:0]          raddr_o,
  output logic      [ADDR_BITS-1:0]          waddr_o,
  output logic      [DATA_WIDTH-1:0]         wdata_o,
  output rqld_pkg::mem_ctl_t                 ctl_o,
  input  wire logic [DATA_WIDTH-1:0]         rd_data_i,
  input  wire logic                          rd_vld_i,
  output logic                               done_o,
  output logic      [rqld_pkg::STATUS_W-1:0] status_o,
  output logic      [DATA_WIDTH-1:0]         data_out_o,
  output logic      [ADDR_BITS-1:0]          index_out_o,
  output logic      [ADDR_BITS:0]            live_count_o
);
  import rqld_pkg::*;

  localparam int CNT_W = ADDR_BITS + 1;

  state_e                 state_q, state_d;
  logic [FUNC_W-1:0]      op_q, op_d;
  logic [DATA_WIDTH-1:0]  din_q, din_d;
  logic [ADDR_BITS-1:0]   cur_q, cur_d;
  logic [ADDR_BITS-1:0]   head_q, head_d;
  logic [ADDR_BITS-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [ADDR_BITS-1:0]   clr_q, clr_d;

  logic                   done_q;
  status_e                status_q;
  logic [DATA_WIDTH-1:0]  dout_q;
  logic [ADDR_BITS-1:0]   idx_q;
  logic [CNT_W-1:0]       live_q;

  logic                   emit;
  status_e                res_status;
  logic [DATA_WIDTH-1:0]  res_data;
  logic [ADDR_BITS-1:0]   res_idx;
  logic [CNT_W-1:0]       cap;
  logic [ADDR_BITS-1:0]   nxt;
  logic [ADDR_BITS-1:0]   start_ptr;

  assign cap = {1'b0, mask_i} + CNT_W'(1);
  assign nxt = (cur_q + ADDR_BITS'(1)) & mask_i;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    unique case (func_i) inside
      FN_PUSH:          start_ptr = tail_q;
      FN_POP, FN_PEEK:  start_ptr = head_q;
      default:          start_ptr = slot_index_i & mask_i;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    din_d      = din_q;
    cur_d      = cur_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    clr_d      = clr_q;
    raddr_o    = cur_q;
    waddr_o    = cur_q;
    wdata_o    = din_q;
    ctl_o      = '0;
    emit       = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_idx    = '0;

    unique case (state_q)
      S_CLEAR: begin
        ctl_o.vld_we = 1'b1;
        waddr_o      = clr_q;
        if (clr_q == mask_i) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ADDR_BITS'(1);
        end
      end
      S_IDLE: begin
        raddr_o = start_ptr;
        if (start_i) begin
          op_d    = func_i;
          din_d   = data_in_i;
          cur_d   = start_ptr;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        case (op_q) inside
          FN_PUSH: begin
            if (count_q >= cap) begin
              emit       = 1'b1;
              res_status = ST_FULL;
            end else if (rd_vld_i) begin
              cur_d   = nxt;
              raddr_o = nxt;
            end else begin
              ctl_o.data_we  = 1'b1;
              ctl_o.vld_we   = 1'b1;
              ctl_o.vld_wbit = 1'b1;
              tail_d  = (tail_q + ADDR_BITS'(1)) & mask_i;
              count_d = count_q + CNT_W'(1);
              emit    = 1'b1;
              res_idx = cur_q;
            end
          end
          FN_POP: begin
            if (count_q == '0) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
            end else if (!rd_vld_i) begin
              cur_d   = nxt;
              raddr_o = nxt;
            end else begin
              ctl_o.vld_we = 1'b1;
              head_d   = nxt;
              count_d  = count_q - CNT_W'(1);
              emit     = 1'b1;
              res_data = rd_data_i;
              res_idx  = cur_q;
            end
          end
          FN_PEEK, FN_READ: begin
            emit = 1'b1;
            if (count_q == '0) begin
              res_status = ST_EMPTY;
            end else begin
              res_idx = cur_q;
              if (rd_vld_i) begin
                res_data = rd_data_i;
              end else begin
                res_status = ST_INVALID;
              end
            end
          end
          FN_DELETE: begin
            emit    = 1'b1;
            res_idx = cur_q;
            if (rd_vld_i) begin
              ctl_o.vld_we = 1'b1;
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
            end else begin
              res_status = ST_INVALID;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      state_d = S_CLEAR;
      clr_d   = '0;
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    din_q <= din_d;
    cur_q <= cur_d;
    if (emit) begin
      status_q <= res_status;
      dout_q   <= res_data;
      idx_q    <= res_idx;
      live_q   <= count_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign data_out_o   = dout_q;
  assign index_out_o  = idx_q;
  assign live_count_o = live_q;

  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap)
    else $error("live count exceeds ring capacity");

  a_done_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_SCAN))
    else $error("result strobe without a scan cycle");

  a_start_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cfg_we_i) |=> (state_q == S_SCAN))
    else $error("accepted command did not enter scan");

  a_full_means_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> ($past(count_q) == $past(cap)))
    else $error("full status with free slots");

endmodule

`default_nettype wire

>>> tb/ring_queue_with_lazy_delete_unit_test.sv
// Self-checking testbench for the ring queue with lazy delete: ring predictor, random commands.
`timescale 1ns / 1ps

module ring_queue_with_lazy_delete_unit_test;
  import rqld_pkg::*;

  localparam int AW = ADDR_BITS_DEF;
  localparam int DW = DATA_WIDTH_DEF;
  localparam int LW = AW + 1;
  localparam int DEPTH = 1 << AW;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = DEPTH + 16;
  localparam int N_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int BLOCK_ITEMS = 32;

  // func codes 5..7 are not decoded
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  localparam logic [SIZE_W-1:0] SIZE_PLAN [N_PHASES] =
    '{4'd3, 4'd1, 4'd8, 4'd0, 4'd5, 4'd15, 4'd2, 4'd9, 4'd4, 4'd6};
  localparam int IDLE_PLAN [3] = '{0, 86, 12};

  typedef struct {
    status_e       status;
    logic [DW-1:0] data;
    logic [AW-1:0] index;
    logic [AW:0]   live;
  } ring_result_t;

  class ring_scoreboard;
    logic [DW-1:0]  slot_data [DEPTH];
    bit             slot_valid [DEPTH];
    int             head_ptr;
    int             tail_ptr;
    int             live;
    logic [SIZE_W-1:0] size_log2;
    ring_result_t   queued [$];
    int             mismatches;
    int             checked;
    int             scans;
    int             status_seen [4];

    function new();
      size_log2 = SIZE_LOG2_RST;
      clear_ring();
    endfunction

    function void clear_ring();
      foreach (slot_valid[k]) slot_valid[k] = 1'b0;
      head_ptr = 0;
      tail_ptr = 0;
      live = 0;
    endfunction

    function void resize(logic [SIZE_W-1:0] v);
      size_log2 = v;
      clear_ring();
    endfunction

    function int ring_mask();
      int s;
      s = int'(size_log2);
      if (s < 1) s = 1;
      if (s > AW) s = AW;
      return (1 << s) - 1;
    endfunction

    function int pending();
      return queued.size();
    endfunction

    // a slot that holds a live entry if there is one, with random bits above the mask
    function logic [AW-1:0] pick_live_slot();
      int mask, p, k;
      mask = ring_mask();
      p = int'($urandom_range(DEPTH - 1)) & mask;
      for (k = 0; k <= mask && !slot_valid[p]; k++) p = (p + 1) & mask;
      p = p | (int'($urandom_range(DEPTH - 1)) & ~mask);
      return AW'(p);
    endfunction

    function void take_command(logic [FUNC_W-1:0] fn, logic [DW-1:0] din,
                               logic [AW-1:0] sidx);
      int mask, cap, idx, p, i;
      ring_result_t r;
      mask = ring_mask();
      cap = mask + 1;
      idx = int'(sidx) & mask;
      r.status = ST_OK;
      r.data = '0;
      r.index = '0;
      head_ptr = head_ptr & mask;
      tail_ptr = tail_ptr & mask;
      case (fn)
        FN_PUSH: begin
          if (live >= cap) begin
            r.status = ST_FULL;
          end else begin
            p = tail_ptr;
            for (i = 0; i < cap && slot_valid[p]; i++) p = (p + 1) & mask;
            if (slot_valid[p]) begin
              r.status = ST_FULL;
            end else begin
              if (p != tail_ptr) scans++;
              slot_data[p] = din;
              slot_valid[p] = 1'b1;
              tail_ptr = (tail_ptr + 1) & mask;
              live++;
              r.index = AW'(p);
            end
          end
        end
        FN_POP: begin
          if (live == 0) begin
            r.status = ST_EMPTY;
          end else begin
            p = head_ptr;
            for (i = 0; i < cap && !slot_valid[p]; i++) p = (p + 1) & mask;
            if (!slot_valid[p]) begin
              r.status = ST_EMPTY;
            end else begin
              r.data = slot_data[p];
              slot_valid[p] = 1'b0;
              head_ptr = (p + 1) & mask;
              live--;
              r.index = AW'(p);
            end
          end
        end
        FN_PEEK, FN_READ: begin
          if (live == 0) begin
            r.status = ST_EMPTY;
          end else begin
            p = (fn == FN_PEEK) ? head_ptr : idx;
            r.index = AW'(p);
            if (!slot_valid[p]) r.status = ST_INVALID;
            else r.data = slot_data[p];
          end
        end
        FN_DELETE: begin
          r.index = AW'(idx);
          if (slot_valid[idx]) begin
            slot_valid[idx] = 1'b0;
            if (live > 0) live--;
          end else begin
            r.status = ST_INVALID;
          end
        end
        default: ;
      endcase
      r.live = LW'(live);
      queued.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [DW-1:0] d, logic [AW-1:0] ix,
                      logic [AW:0] lc);
      ring_result_t e;
      if (queued.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d index %0d", st, ix));
        return;
      end
      e = queued.pop_front();
      checked++;
      status_seen[e.status]++;
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", st, e.status));
      if (d !== e.data)
        report_mismatch($sformatf("data_out %h, want %h", d, e.data));
      if (ix !== e.index)
        report_mismatch($sformatf("index_out %0d, want %0d", ix, e.index));
      if (lc !== e.live)
        report_mismatch($sformatf("live_count %0d, want %0d", lc, e.live));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] func_i;
  logic [DW-1:0]     data_in_i;
  logic [AW-1:0]     slot_index_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [SIZE_W-1:0] size_log2_i;
  logic              done_o;
  logic [STATUS_W-1:0] status_o;
  logic [DW-1:0]     data_out_o;
  logic [AW-1:0]     index_out_o;
  logic [AW:0]       live_count_o;

  ring_scoreboard sb;
  int commands_sent;
  int idle_cycles;

  ring_queue_with_lazy_delete_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .data_in_i    (data_in_i),
    .slot_index_i (slot_index_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .size_log2_i  (size_log2_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .index_out_o  (index_out_o),
    .live_count_o (live_count_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, data_out_o, index_out_o, live_count_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high across back-to-back commands
  task issue(logic [FUNC_W-1:0] fn, logic [DW-1:0] din, logic [AW-1:0] sidx);
    start <= 1'b1;
    func_i <= fn;
    data_in_i <= din;
    slot_index_i <= sidx;
    do @(posedge clk_i); while (busy);
    sb.take_command(fn, din, sidx);
    commands_sent++;
  endtask

  task pause();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task write_size(logic [SIZE_W-1:0] v);
    cfg_valid_i <= 1'b1;
    size_log2_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.resize(v);
  endtask

  task random_command(int push_w);
    logic [FUNC_W-1:0] fn;
    logic [DW-1:0]     d;
    logic [AW-1:0]     ix;
    int                roll;
    if (int'($urandom_range(99)) < push_w) begin
      fn = FN_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40) fn = FN_POP;
      else if (roll < 55) fn = FN_PEEK;
      else if (roll < 72) fn = FN_READ;
      else if (roll < 95) fn = FN_DELETE;
      else fn = FUNC_W'($urandom_range(int'(FN_SPARE_HI), int'(FN_SPARE_LO)));
    end
    case ($urandom_range(9))
      0: d = '0;
      1: d = '1;
      default: d = DW'($urandom);
    endcase
    if ($urandom_range(1) == 1) ix = sb.pick_live_slot();
    else ix = AW'($urandom_range(DEPTH - 1));
    issue(fn, d, ix);
  endtask

  initial begin
    int idle_pct, blk_idle, push_w, n;
    sb = new();
    commands_sent = 0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    func_i <= FN_PUSH;
    data_in_i <= '0;
    slot_index_i <= '0;
    cfg_valid_i <= 1'b0;
    size_log2_i <= SIZE_LOG2_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queue, then a hole that pop and peek must handle
    issue(FN_POP, '0, '0);
    issue(FN_PEEK, '0, '0);
    issue(FN_READ, '0, 8'hff);
    issue(FN_DELETE, '0, 8'hff);
    issue(FN_SPARE_HI, '1, 8'hff);
    issue(FN_PUSH, 32'h0000_0000, '0);
    issue(FN_PUSH, 32'hffff_ffff, '0);
    issue(FN_PUSH, 32'ha5a5_a5a5, '0);
    issue(FN_READ, '0, 8'd1);
    issue(FN_READ, '0, 8'd200);
    issue(FN_DELETE, '0, 8'd1);
    issue(FN_READ, '0, 8'd1);
    issue(FN_POP, '0, '0);
    issue(FN_PEEK, '0, '0);
    issue(FN_POP, '0, '0);
    issue(FN_POP, '0, '0);

    // two-slot ring: full, wrap, masked delete, push scanning past a live slot
    drain();
    write_size(4'd1);
    issue(FN_PUSH, 32'h1234_5678, '0);
    issue(FN_PUSH, 32'h9abc_def0, '0);
    issue(FN_PUSH, 32'h5555_aaaa, '0);
    issue(FN_POP, '0, '0);
    issue(FN_PUSH, 32'h0f0f_0f0f, '0);
    issue(FN_DELETE, '0, 8'hff);
    issue(FN_PUSH, 32'hdead_beef, '0);
    issue(FN_POP, '0, '0);
    issue(FN_PUSH, 32'h8000_0001, '0);
    issue(FN_PEEK, '0, '0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_size(SIZE_PLAN[ph]);
      idle_pct = IDLE_PLAN[ph % 3];
      blk_idle = idle_pct;
      push_w = 50;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % BLOCK_ITEMS == 0) begin
          blk_idle = ($urandom_range(3) == 0) ? 0 : idle_pct;
          case ($urandom_range(2))
            0: push_w = 80;
            1: push_w = 50;
            default: push_w = 25;
          endcase
        end
        if (idle_pct == 12 && $urandom_range(19) == 0) drain();
        while (int'($urandom_range(99)) < blk_idle) pause();
        random_command(push_w);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands over %0d ring sizes, %0d pushes scanned past live slots.",
             commands_sent, N_PHASES + 2, sb.scans);
    $display("Results: %0d ok, %0d full, %0d empty, %0d invalid slot; %0d mismatches.",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_INVALID], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
